// File: rtl/core/record_bubble_sorter_macros.svh
// assertion macros for the record bubble sorter
// no dependencies; taken in by files that carry concurrent assertions
`ifndef RECORD_BUBBLE_SORTER_MACROS_SVH
`define RECORD_BUBBLE_SORTER_MACROS_SVH

`ifndef ASSERT_OFF

// property that must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/rbs_pkg.sv
// shared types and constants for the record bubble sorter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rbs_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [23:0] diameter;
        logic [15:0] satellites;
        logic        life;
        logic [15:0] tag;
    } t_rec;

    typedef struct packed {
        logic [23:0] diameter;
        logic [15:0] satellites;
        logic        life;
        logic [15:0] record_tag;
        logic        last_record;
    } t_in_item;

    typedef struct packed {
        logic [23:0] sorted_diameter;
        logic [15:0] sorted_satellites;
        logic        sorted_life;
        logic [15:0] sorted_tag;
        logic        last_out;
        logic        overflow;
    } t_out_item;

    // one write and one read port request to the record store
    typedef struct packed {
        logic we;
        t_idx waddr;
        t_rec wdata;
        t_idx raddr;
    } t_mem_req;

endpackage

`default_nettype wire

// File: rtl/core/record_bubble_sorter.sv
// top level of the record bubble sorter: load sequencer, sort sequencer, output
// depends on rbs_pkg, rbs_store, rbs_cmp_swap and record_bubble_sorter_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "record_bubble_sorter_macros.svh"

// usage
// - records come in on i_item; a transfer happens on a clock edge with start
//   high and busy low. records load one per cycle while busy stays low
// - the record with last_record set closes the batch; busy then rises and the
//   block sorts the stored records, ascending by diameter then satellites,
//   stable for equal keys
// - records beyond the store capacity are dropped; every result of that batch
//   then carries overflow
// - results leave on o_result, one per stored record, each valid for exactly
//   one cycle with o_strobe high; last_out marks the final one
// - the receiver cannot stall; results are never held back
// - rate: the sort runs one compare-exchange per cycle through a
//   single shared unit, with the bubbling record carried in a register;
//   early exit after a pass with no exchange. output follows, one result
//   per stored record, each registered from the store's read data; the pace
//   is set by the single read and write port of the store
// - reset (synchronous, active low) empties the batch and clears overflow;
//   the store itself is not cleared, only entries written this batch are read
module record_bubble_sorter (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    input  rbs_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_strobe,
    output rbs_pkg::t_out_item o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD0,
        S_LD0,
        S_CMP,
        S_WLAST,
        S_OUT
    } t_state;

    t_state             r_state,   n_state;
    rbs_pkg::t_cnt      r_count,   n_count;
    logic               r_ovf,     n_ovf;
    rbs_pkg::t_idx      r_k,       n_k;
    rbs_pkg::t_idx      r_lim,     n_lim;
    logic               r_swapped, n_swapped;
    rbs_pkg::t_rec      r_cur,     n_cur;
    logic               r_strobe,  n_strobe;
    rbs_pkg::t_out_item r_result,  n_result;

    rbs_pkg::t_mem_req  mem_req;
    rbs_pkg::t_rec      mem_rdata;
    rbs_pkg::t_rec      cmp_lo;
    rbs_pkg::t_rec      cmp_hi;
    logic               cmp_greater;
    rbs_pkg::t_idx      last_idx;
    logic               accept;

    rbs_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // bubbling record against the one just read
    rbs_cmp_swap u_cmp (
        .i_cur     (r_cur),
        .i_next    (mem_rdata),
        .o_lo      (cmp_lo),
        .o_hi      (cmp_hi),
        .o_greater (cmp_greater)
    );

    assign accept   = start && (r_state == S_IDLE);
    assign last_idx = rbs_pkg::t_idx'(r_count - rbs_pkg::t_cnt'(1));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_k       = r_k;
        n_lim     = r_lim;
        n_swapped = r_swapped;
        n_cur     = r_cur;
        n_strobe  = 1'b0;
        n_result  = r_result;

        mem_req.we    = 1'b0;
        mem_req.waddr = r_k;
        mem_req.wdata = cmp_lo;
        mem_req.raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_count < rbs_pkg::t_cnt'(rbs_pkg::MAX_RECORDS)) begin
                        mem_req.we               = 1'b1;
                        mem_req.waddr            = rbs_pkg::t_idx'(r_count);
                        mem_req.wdata.diameter   = i_item.diameter;
                        mem_req.wdata.satellites = i_item.satellites;
                        mem_req.wdata.life       = i_item.life;
                        mem_req.wdata.tag        = i_item.record_tag;
                        n_count                  = r_count + rbs_pkg::t_cnt'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_item.last_record) begin
                        n_lim   = rbs_pkg::t_idx'(n_count - rbs_pkg::t_cnt'(1));
                        n_state = S_RD0;
                    end
                end
            end
            S_RD0: begin
                // read of entry zero issued here
                n_k = '0;
                if (r_lim == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_LD0;
                end
            end
            S_LD0: begin
                n_cur         = mem_rdata;
                mem_req.raddr = rbs_pkg::t_idx'(1);
                n_k           = '0;
                n_swapped     = 1'b0;
                n_state       = S_CMP;
            end
            S_CMP: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_k;
                mem_req.wdata = cmp_lo;
                n_cur         = cmp_hi;
                if (cmp_greater) begin
                    n_swapped = 1'b1;
                end
                if (r_k + rbs_pkg::t_idx'(1) == r_lim) begin
                    n_state = S_WLAST;
                end else begin
                    n_k           = r_k + rbs_pkg::t_idx'(1);
                    mem_req.raddr = r_k + rbs_pkg::t_idx'(2);
                end
            end
            S_WLAST: begin
                // largest of the pass settles at the end; entry zero read for what follows
                mem_req.we    = 1'b1;
                mem_req.waddr = r_lim;
                mem_req.wdata = r_cur;
                mem_req.raddr = '0;
                n_k           = '0;
                if (!r_swapped || r_lim == rbs_pkg::t_idx'(1)) begin
                    n_state = S_OUT;
                end else begin
                    n_lim   = r_lim - rbs_pkg::t_idx'(1);
                    n_state = S_LD0;
                end
            end
            S_OUT: begin
                n_strobe                   = 1'b1;
                n_result.sorted_diameter   = mem_rdata.diameter;
                n_result.sorted_satellites = mem_rdata.satellites;
                n_result.sorted_life       = mem_rdata.life;
                n_result.sorted_tag        = mem_rdata.tag;
                n_result.last_out          = (r_k == last_idx);
                n_result.overflow          = r_ovf;
                mem_req.raddr              = r_k + rbs_pkg::t_idx'(1);
                if (r_k == last_idx) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + rbs_pkg::t_idx'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_strobe <= n_strobe;
        end
        r_k       <= n_k;
        r_lim     <= n_lim;
        r_swapped <= n_swapped;
        r_cur     <= n_cur;
        r_result  <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // fill count never passes the store depth
    `ASSERT_HOLDS(a_count_in_range, i_clk, i_rst_n,
        r_count <= rbs_pkg::t_cnt'(rbs_pkg::MAX_RECORDS))
    // a record is dropped only once the store is full
    `ASSERT_HOLDS(a_ovf_only_full, i_clk, i_rst_n,
        !r_ovf || (r_count == rbs_pkg::t_cnt'(rbs_pkg::MAX_RECORDS)))
    // sorting and output always work on a non-empty batch
    `ASSERT_HOLDS(a_batch_not_empty, i_clk, i_rst_n,
        (r_state == S_IDLE) || (r_count != '0))
    // the final transfer of a batch ends the output burst
    `ASSERT_NEXT(a_last_ends_batch, i_clk, i_rst_n,
        o_strobe && o_result.last_out, !o_strobe)

endmodule

`default_nettype wire

// File: rtl/core/rbs_store.sv
// record store: one write port, one read port with registered read data
// depends on rbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module rbs_store (
    input  wire               i_clk,
    input  rbs_pkg::t_mem_req i_req,
    output rbs_pkg::t_rec     o_rdata
);

    rbs_pkg::t_rec r_mem [rbs_pkg::MAX_RECORDS];
    rbs_pkg::t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/rbs_cmp_swap.sv
// shared compare-exchange unit: orders two records by diameter then satellites
// depends on rbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module rbs_cmp_swap (
    input  rbs_pkg::t_rec i_cur,
    input  rbs_pkg::t_rec i_next,
    output rbs_pkg::t_rec o_lo,
    output rbs_pkg::t_rec o_hi,
    output logic          o_greater
);

    // strictly greater only, so equal keys keep their order
    always_comb begin
        if (i_cur.diameter != i_next.diameter) begin
            o_greater = (i_cur.diameter > i_next.diameter);
        end else begin
            o_greater = (i_cur.satellites > i_next.satellites);
        end
        o_lo = o_greater ? i_next : i_cur;
        o_hi = o_greater ? i_cur : i_next;
    end

endmodule

`default_nettype wire

// File: tb/rbs_result_checker.sv
`timescale 1ns / 1ps
// result checker for the record bubble sorter: follows record and result transfers,
// keeps its own sorted copy of each batch and compares every result field by field
// depends on rbs_pkg
module rbs_result_checker (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire                i_busy,
    input  rbs_pkg::t_in_item  i_item,
    input  wire                i_strobe,
    input  rbs_pkg::t_out_item i_result,
    output int                 o_mismatches,
    output int                 o_pending,
    output int                 o_batches,
    output int                 o_dropped_batches,
    output int                 o_results
);

    rbs_pkg::t_rec      batch_store [rbs_pkg::MAX_RECORDS];
    int                 batch_fill;
    bit                 batch_dropped;
    rbs_pkg::t_out_item sorted_q [$];
    int                 mismatch_cnt  = 0;
    int                 batch_cnt     = 0;
    int                 dropped_cnt   = 0;
    int                 result_cnt    = 0;

    assign o_mismatches      = mismatch_cnt;
    assign o_pending         = sorted_q.size();
    assign o_batches         = batch_cnt;
    assign o_dropped_batches = dropped_cnt;
    assign o_results         = result_cnt;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_cnt++;
    endtask

    // strictly greater only, so equal keys never move past each other
    function automatic bit key_greater(input rbs_pkg::t_rec a, input rbs_pkg::t_rec b);
        if (a.diameter != b.diameter)
            return a.diameter > b.diameter;
        return a.satellites > b.satellites;
    endfunction

    task automatic sort_and_queue_batch();
        rbs_pkg::t_rec      held;
        rbs_pkg::t_out_item res;
        bit                 swapped;
        swapped = 1'b1;
        for (int pass = 0; pass + 1 < batch_fill && swapped; pass++) begin
            swapped = 1'b0;
            for (int k = 0; k + 1 < batch_fill - pass; k++) begin
                if (key_greater(batch_store[k], batch_store[k + 1])) begin
                    held               = batch_store[k];
                    batch_store[k]     = batch_store[k + 1];
                    batch_store[k + 1] = held;
                    swapped            = 1'b1;
                end
            end
        end
        for (int k = 0; k < batch_fill; k++) begin
            res.sorted_diameter   = batch_store[k].diameter;
            res.sorted_satellites = batch_store[k].satellites;
            res.sorted_life       = batch_store[k].life;
            res.sorted_tag        = batch_store[k].tag;
            res.last_out          = (k == batch_fill - 1);
            res.overflow          = batch_dropped;
            sorted_q.push_back(res);
        end
        batch_cnt++;
        if (batch_dropped)
            dropped_cnt++;
        batch_fill    = 0;
        batch_dropped = 1'b0;
    endtask

    always @(posedge i_clk) begin
        rbs_pkg::t_out_item want;
        if (!i_rst_n) begin
            batch_fill    = 0;
            batch_dropped = 1'b0;
        end else begin
            if (i_strobe) begin
                if (sorted_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d", result_cnt));
                end else begin
                    want = sorted_q.pop_front();
                    if (i_result.sorted_diameter != want.sorted_diameter)
                        report_mismatch($sformatf("result %0d diameter %h, want %h",
                            result_cnt, i_result.sorted_diameter, want.sorted_diameter));
                    if (i_result.sorted_satellites != want.sorted_satellites)
                        report_mismatch($sformatf("result %0d satellites %h, want %h",
                            result_cnt, i_result.sorted_satellites, want.sorted_satellites));
                    if (i_result.sorted_life != want.sorted_life)
                        report_mismatch($sformatf("result %0d life %b, want %b",
                            result_cnt, i_result.sorted_life, want.sorted_life));
                    if (i_result.sorted_tag != want.sorted_tag)
                        report_mismatch($sformatf("result %0d tag %h, want %h",
                            result_cnt, i_result.sorted_tag, want.sorted_tag));
                    if (i_result.last_out != want.last_out)
                        report_mismatch($sformatf("result %0d last_out %b, want %b",
                            result_cnt, i_result.last_out, want.last_out));
                    if (i_result.overflow != want.overflow)
                        report_mismatch($sformatf("result %0d overflow %b, want %b",
                            result_cnt, i_result.overflow, want.overflow));
                end
                result_cnt++;
            end
            if (i_start && !i_busy) begin
                if (batch_fill < rbs_pkg::MAX_RECORDS) begin
                    batch_store[batch_fill].diameter   = i_item.diameter;
                    batch_store[batch_fill].satellites = i_item.satellites;
                    batch_store[batch_fill].life       = i_item.life;
                    batch_store[batch_fill].tag        = i_item.record_tag;
                    batch_fill++;
                end else begin
                    batch_dropped = 1'b1;
                end
                if (i_item.last_record)
                    sort_and_queue_batch();
            end
        end
    end

endmodule

// File: tb/tb_record_bubble_sorter.sv
`timescale 1ns / 1ps
// top of the record bubble sorter testbench: clock, reset, record stimulus and verdict
// depends on rbs_pkg, record_bubble_sorter and rbs_result_checker
module tb_record_bubble_sorter;

    localparam int HALF_PERIOD  = 6;
    localparam int RECORD_GOAL  = 310;
    // records in this window are sent without random idling
    localparam int QUIET_FROM   = 150;
    localparam int QUIET_TO     = 240;
    // settle time after the last result, long enough for a stray extra output
    localparam int SETTLE_CYCLES = 4 * rbs_pkg::MAX_RECORDS;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    rbs_pkg::t_in_item  i_item  = '0;
    logic               busy;
    logic               o_strobe;
    rbs_pkg::t_out_item o_result;

    int mismatches;
    int pending;
    int batches;
    int dropped_batches;
    int results_seen;
    int records_sent = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    record_bubble_sorter i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // watches both channels, predicts each sorted batch and counts mismatches
    rbs_result_checker i_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_item            (i_item),
        .i_strobe          (o_strobe),
        .i_result          (o_result),
        .o_mismatches      (mismatches),
        .o_pending         (pending),
        .o_batches         (batches),
        .o_dropped_batches (dropped_batches),
        .o_results         (results_seen)
    );

    // one record transfer; called and returns at a falling edge
    task automatic send_record(input rbs_pkg::t_in_item rec);
        // random idling, about 12 in a hundred, except inside the quiet window
        if ((records_sent < QUIET_FROM || records_sent >= QUIET_TO)
            && $urandom_range(99) < 12) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= rec;
        // busy read in the active region still holds its pre-edge value
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        records_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_fields(input logic [23:0] diam, input logic [15:0] sats,
                               input logic life, input logic [15:0] tag,
                               input logic last);
        rbs_pkg::t_in_item rec;
        rec.diameter    = diam;
        rec.satellites  = sats;
        rec.life        = life;
        rec.record_tag  = tag;
        rec.last_record = last;
        send_record(rec);
    endtask

    // batch with random content; some batches draw keys from a tiny range so
    // that ties and stability get exercised, others mix in extreme values
    task automatic send_random_batch(input int size);
        rbs_pkg::t_in_item rec;
        bit                tie_heavy;
        tie_heavy = ($urandom_range(2) == 0);
        for (int k = 0; k < size; k++) begin
            if (tie_heavy) begin
                rec.diameter   = 24'($urandom_range(3));
                rec.satellites = 16'($urandom_range(3));
            end else begin
                rec.diameter   = 24'($urandom);
                rec.satellites = 16'($urandom);
                if ($urandom_range(9) == 0)
                    rec.diameter = $urandom_range(1) ? '1 : '0;
                if ($urandom_range(9) == 0)
                    rec.satellites = $urandom_range(1) ? '1 : '0;
            end
            rec.life        = 1'($urandom);
            rec.record_tag  = 16'($urandom);
            rec.last_record = (k == size - 1);
            send_record(rec);
        end
    endtask

    // hold off the sender until every expected result has been seen
    task automatic drain_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int size;
        int batch_no;

        // synchronous reset, released at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single-record batches at the field extremes
        send_fields(24'hFFFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1);
        send_fields(24'h000000, 16'h0000, 1'b0, 16'h0000, 1'b1);

        // mixed extremes, equal diameters split by satellites, and an exact
        // key tie that must keep arrival order
        send_fields(24'h000005, 16'h0007, 1'b1, 16'h0001, 1'b0);
        send_fields(24'h000005, 16'h0003, 1'b0, 16'h0002, 1'b0);
        send_fields(24'h000000, 16'hFFFF, 1'b1, 16'h0003, 1'b0);
        send_fields(24'hFFFFFF, 16'h0000, 1'b0, 16'h0004, 1'b0);
        send_fields(24'h000005, 16'h0003, 1'b1, 16'h0005, 1'b0);
        send_fields(24'h000000, 16'h0000, 1'b0, 16'h0006, 1'b1);

        // already in order, so the first pass finds nothing to exchange
        send_fields(24'h000001, 16'h0009, 1'b0, 16'h0010, 1'b0);
        send_fields(24'h000002, 16'h0000, 1'b1, 16'h0011, 1'b0);
        send_fields(24'h000002, 16'h0001, 1'b0, 16'h0012, 1'b0);
        send_fields(24'h800000, 16'h8000, 1'b1, 16'h0013, 1'b1);

        // reverse order, worst case for the number of passes
        send_fields(24'hFFFFFF, 16'hFFFF, 1'b1, 16'h0020, 1'b0);
        send_fields(24'hFFFFFF, 16'hFFFE, 1'b0, 16'h0021, 1'b0);
        send_fields(24'h7FFFFF, 16'h0000, 1'b1, 16'h0022, 1'b0);
        send_fields(24'h000001, 16'h8000, 1'b0, 16'h0023, 1'b0);
        send_fields(24'h000000, 16'h0001, 1'b1, 16'h0024, 1'b1);

        // identical keys throughout, only the tags tell them apart
        send_fields(24'h123456, 16'h4321, 1'b0, 16'hAAAA, 1'b0);
        send_fields(24'h123456, 16'h4321, 1'b1, 16'h5555, 1'b0);
        send_fields(24'h123456, 16'h4321, 1'b0, 16'h0F0F, 1'b0);
        send_fields(24'h123456, 16'h4321, 1'b1, 16'hF0F0, 1'b1);

        drain_results();

        // random batches, mostly small; one exactly fills the store and one
        // runs past it so that the record marked last is itself dropped
        batch_no = 0;
        while (records_sent < RECORD_GOAL) begin
            if (batch_no == 3)
                size = rbs_pkg::MAX_RECORDS;
            else if (batch_no == 9)
                size = rbs_pkg::MAX_RECORDS + $urandom_range(1, 4);
            else if ($urandom_range(19) == 0
                     && records_sent + rbs_pkg::MAX_RECORDS + 3 <= RECORD_GOAL)
                size = $urandom_range(rbs_pkg::MAX_RECORDS - 2, rbs_pkg::MAX_RECORDS + 3);
            else
                size = $urandom_range(1, 10);
            send_random_batch(size);
            if ($urandom_range(5) == 0)
                drain_results();
            batch_no++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d records in %0d batches, %0d of them over capacity",
                 records_sent, batches, dropped_batches);
        $display("checked %0d sorted results, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // hard limit, many times the slowest legal run
    initial begin
        #(5_000_000);
        $display("run timed out with %0d results outstanding", pending);
        $display("FAIL");
        $finish;
    end

endmodule
